FILE: rtl/mbe_pkg.sv
package mbe_pkg;

	// Plane values: signed Q3.28 held in 32 bits
	localparam int FRAC_BITS = 28;
	localparam int W         = FRAC_BITS + 4;
	localparam int OPD_W     = W + 1;          // multiplier operand width
	localparam int PROD_W    = 2 * OPD_W;      // full product width

	// Field and register widths
	localparam int PIX_W   = 12;
	localparam int CTR_W   = 13;
	localparam int D_W     = CTR_W + 1;        // 2*pixel - center, signed
	localparam int STEP_W  = 31;
	localparam int LIM_W   = 16;
	localparam int CNT_OUT = 16;

	// Register map (word index = paddr[4:2])
	localparam logic [2:0] REG_PIXEL_STEP = 3'd0;
	localparam logic [2:0] REG_CENTER_X   = 3'd1;
	localparam logic [2:0] REG_CENTER_Y   = 3'd2;
	localparam logic [2:0] REG_OFFSET_RE  = 3'd3;
	localparam logic [2:0] REG_OFFSET_IM  = 3'd4;
	localparam logic [2:0] REG_MAX_ITER   = 3'd5;

	localparam logic [STEP_W-1:0] RST_PIXEL_STEP = 31'd1879048;
	localparam logic [CTR_W-1:0]  RST_CENTER     = 13'd4096;
	localparam logic [LIM_W-1:0]  RST_MAX_ITER   = 16'd100;

	// Escape bound 4.0 on the unsigned sum of two squares
	localparam logic [W:0] ESC_BOUND = (W + 1)'(4) << FRAC_BITS;

	localparam logic signed [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

	// Sequencer states
	typedef enum logic [8:0] {
		ST_IDLE = 9'b0_0000_0001,
		ST_MAPX = 9'b0_0000_0010,
		ST_MAPY = 9'b0_0000_0100,
		ST_MAPI = 9'b0_0000_1000,
		ST_SQR  = 9'b0_0001_0000,
		ST_SQI  = 9'b0_0010_0000,
		ST_CRS  = 9'b0_0100_0000,
		ST_FIN  = 9'b0_1000_0000,
		ST_UPD  = 9'b1_0000_0000
	} mbe_state_t;

	// Clamp a product-width value to W bits
	function automatic logic signed [W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-W:0] hi;
		hi = v[PROD_W-1:W-1];
		if (hi == '0 || hi == '1)
			return v[W-1:0];
		else if (v[PROD_W-1])
			return NEG_MIN;
		else
			return POS_MAX;
	endfunction

	// Floor shift right, then clamp
	function automatic logic signed [W-1:0] shift_sat(input logic signed [PROD_W-1:0] v,
		input int sh);
		logic signed [PROD_W-1:0] s;
		s = v >>> sh;
		return sat_prod(s);
	endfunction

	// Clamp a W+1 bit sum to W bits
	function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] v);
		if (v[W] == v[W-1])
			return v[W-1:0];
		else if (v[W])
			return NEG_MIN;
		else
			return POS_MAX;
	endfunction

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		return sat_sum(s);
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		return sat_sum(s);
	endfunction

endpackage

FILE: rtl/mandelbrot_escape_time_core.sv
// After an input word is accepted, the sequencer maps the pixel to c (MAPX, MAPY, MAPI) and then
// iterates until the count reaches max_iter or the point escapes; it waits in FIN for a free output
// register. One pixel is in flight at a time, and each iteration takes four steps on a single 33x33
// multiplier (re^2, im^2, re*im, then the z update).
// Input is taken only while idle; a finished result waits in the output register.
// Reset (arst_n low, async): sequencer idle, output empty, registers to defaults.
module mandelbrot_escape_time_core #(
	parameter int COORD_BITS = 12,
	parameter int ITER_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] iter_count
	output logic        m_axis_tuser,   // [0] inside_set
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mbe_pkg::*;

	localparam logic [PIX_W-1:0] PIX_MASK = (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} :
		PIX_W'((1 << COORD_BITS) - 1);

	// configuration registers
	logic [STEP_W-1:0]      pixel_step_q;
	logic [CTR_W-1:0]       center_x_q;
	logic [CTR_W-1:0]       center_y_q;
	logic signed [W-1:0]    offset_re_q;
	logic signed [W-1:0]    offset_im_q;
	logic [LIM_W-1:0]       max_iter_q;

	// datapath
	mbe_state_t             state_q;
	logic [PIX_W-1:0]       px_q;
	logic [PIX_W-1:0]       py_q;
	logic signed [W-1:0]    cre_q;
	logic signed [W-1:0]    cim_q;
	logic signed [W-1:0]    zr_q;
	logic signed [W-1:0]    zi_q;
	logic signed [W-1:0]    sr_q;
	logic signed [W-1:0]    si_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [ITER_BITS-1:0]   count_q;

	logic                   out_valid_q;
	logic [ITER_BITS-1:0]   out_count_q;
	logic                   out_inside_q;

	logic                   cfg_wr;
	logic                   in_acc;
	logic                   out_free;
	logic [ITER_BITS-1:0]   limit;
	logic [ITER_BITS-1:0]   cnt_nx;
	logic signed [D_W-1:0]  dx;
	logic signed [D_W-1:0]  dy;
	logic signed [OPD_W-1:0] mul_a;
	logic signed [OPD_W-1:0] mul_b;
	logic signed [W-1:0]    si_now;
	logic [W:0]             mag;
	logic                   escaped;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign in_acc   = s_axis_tvalid & s_axis_tready;
	assign out_free = ~out_valid_q | m_axis_tready;
	assign limit    = max_iter_q[ITER_BITS-1:0];
	assign cnt_nx   = count_q + 1'b1;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = CNT_OUT'(out_count_q);
	assign m_axis_tuser  = out_inside_q;

	// register file write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_step_q <= RST_PIXEL_STEP;
			center_x_q   <= RST_CENTER;
			center_y_q   <= RST_CENTER;
			offset_re_q  <= '0;
			offset_im_q  <= '0;
			max_iter_q   <= RST_MAX_ITER;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_PIXEL_STEP: pixel_step_q <= pwdata[STEP_W-1:0];
				REG_CENTER_X:   center_x_q   <= pwdata[CTR_W-1:0];
				REG_CENTER_Y:   center_y_q   <= pwdata[CTR_W-1:0];
				REG_OFFSET_RE:  offset_re_q  <= pwdata[W-1:0];
				REG_OFFSET_IM:  offset_im_q  <= pwdata[W-1:0];
				REG_MAX_ITER:   max_iter_q   <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// register file read
	always_comb begin
		case (paddr[4:2])
			REG_PIXEL_STEP: prdata = 32'(pixel_step_q);
			REG_CENTER_X:   prdata = 32'(center_x_q);
			REG_CENTER_Y:   prdata = 32'(center_y_q);
			REG_OFFSET_RE:  prdata = 32'(offset_re_q);
			REG_OFFSET_IM:  prdata = 32'(offset_im_q);
			REG_MAX_ITER:   prdata = 32'(max_iter_q);
			default:        prdata = '0;
		endcase
	end

	// pixel offsets from center, in half pixels
	assign dx = $signed({1'b0, px_q, 1'b0}) - $signed({1'b0, center_x_q});
	assign dy = $signed({1'b0, py_q, 1'b0}) - $signed({1'b0, center_y_q});

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_MAPX: begin
				mul_a = $signed({2'b00, pixel_step_q});
				mul_b = OPD_W'(dx);
			end
			ST_MAPY: begin
				mul_a = $signed({2'b00, pixel_step_q});
				mul_b = OPD_W'(dy);
			end
			ST_SQR: begin
				mul_a = OPD_W'(zr_q);
				mul_b = OPD_W'(zr_q);
			end
			ST_SQI: begin
				mul_a = OPD_W'(zi_q);
				mul_b = OPD_W'(zi_q);
			end
			ST_CRS: begin
				mul_a = OPD_W'(zr_q);
				mul_b = OPD_W'(zi_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// escape test on the squares
	assign si_now  = shift_sat(prod_q, FRAC_BITS);
	assign mag     = {1'b0, sr_q} + {1'b0, si_now};
	assign escaped = (mag >= ESC_BOUND);

	// multiplier product register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// sequencer and iteration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_MAPX;
				end
				ST_MAPX: state_q <= ST_MAPY;
				ST_MAPY: state_q <= ST_MAPI;
				ST_MAPI: begin
					count_q <= '0;
					state_q <= ST_SQR;
				end
				ST_SQR: state_q <= ST_SQI;
				ST_SQI: state_q <= ST_CRS;
				ST_CRS: begin
					if (escaped) begin
						state_q <= ST_FIN;
					end else begin
						count_q <= cnt_nx;
						if (cnt_nx >= limit)
							state_q <= ST_FIN;
						else
							state_q <= ST_UPD;
					end
				end
				ST_UPD: state_q <= ST_SQR;
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q <= s_axis_tdata[PIX_W-1:0] & PIX_MASK;
				py_q <= s_axis_tdata[2*PIX_W-1:PIX_W] & PIX_MASK;
			end
			ST_MAPY: cre_q <= sat_sub(shift_sat(prod_q, 1), offset_re_q);
			ST_MAPI: begin
				cim_q <= sat_sub(shift_sat(prod_q, 1), offset_im_q);
				zr_q  <= '0;
				zi_q  <= '0;
			end
			ST_SQI: sr_q <= shift_sat(prod_q, FRAC_BITS);
			ST_CRS: si_q <= si_now;
			// z = z*z + c; the product register holds re*im here
			ST_UPD: begin
				zr_q <= sat_add(sat_sub(sr_q, si_q), cre_q);
				zi_q <= sat_add(shift_sat(prod_q, FRAC_BITS - 1), cim_q);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_count_q  <= count_q;
			out_inside_q <= (count_q == limit);
		end
	end

endmodule

FILE: rtl/mbe_chk.sv
module mbe_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// a stalled output word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	// a stalled output word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// the engine is busy right after taking a pixel
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again while iterating");

	// a pixel inside the set always counted at least one iteration
	a_inside_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata != 16'd0)
		else $error("inside flag with zero count");

	// every result counts at least one iteration
	a_cnt_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata != 16'd0)
		else $error("zero iteration count");

endmodule

bind mandelbrot_escape_time_core mbe_chk u_mbe_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
